// ===== design/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg - shared constants for the ladder switch decoder
// Field widths, switch codes and the ladder threshold table.
// ----------------------------------------------------------------------------
`default_nettype none

package lsd_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int TIME_BITS_DEF   = 32;

	localparam int CODE_W    = 4;
	localparam int HOLD_MS_W = 16;
	localparam int OUT_W     = 8;
	localparam int THR_W     = 16;
	localparam int NUM_THR   = 8;

	localparam logic [CODE_W-1:0]    CODE_NONE     = 4'd8;
	localparam logic [HOLD_MS_W-1:0] HOLD_MS_RESET = 16'd2000;

	// nominal ladder levels
	localparam int LVL_MUTE   = 91;
	localparam int LVL_BANK   = 168;
	localparam int LVL_MANPGM = 233;
	localparam int LVL_SW1    = 289;
	localparam int LVL_SW2    = 337;
	localparam int LVL_SW3    = 380;
	localparam int LVL_SW4    = 416;
	localparam int LVL_SW5    = 450;
	localparam int LVL_NONE   = 1013;

	// midpoints between adjacent levels
	localparam logic [THR_W-1:0] THRESH [NUM_THR] = '{
		16'((LVL_MUTE + LVL_BANK) / 2),
		16'((LVL_BANK + LVL_MANPGM) / 2),
		16'((LVL_MANPGM + LVL_SW1) / 2),
		16'((LVL_SW1 + LVL_SW2) / 2),
		16'((LVL_SW2 + LVL_SW3) / 2),
		16'((LVL_SW3 + LVL_SW4) / 2),
		16'((LVL_SW4 + LVL_SW5) / 2),
		16'((LVL_SW5 + LVL_NONE) / 2)
	};

endpackage

`default_nettype wire

// ===== design/ladder_switch_decoder_with_hold.sv =====
// ----------------------------------------------------------------------------
// ladder_switch_decoder_with_hold - ladder switch decoder with hold events
// Path: an accepted poll passes the input register, then the result register,
//   before its event leaves; polls that cause no event leave no output.
// Throughput: one poll per cycle while the receiver takes events; the state
//   update is a single pass of classify, compare and one TIME_BITS subtract between the two registers.
// Reset (arst_n, async low): stored code none, hold disarmed, change time 0,
//   hold_ms 2000, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module ladder_switch_decoder_with_hold #(
	parameter int SAMPLE_BITS = lsd_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = lsd_pkg::TIME_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// hold_ms register write
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [lsd_pkg::HOLD_MS_W-1:0]        cfg_data,
	// poll in: first_sample, second_sample, now_ms (low bit up), zero pad
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [((2*SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
	// event out: tdata = switch_code, zero pad; tuser = is_hold
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [lsd_pkg::OUT_W-1:0]                 m_tdata,
	output logic [0:0]                                m_tuser
);
	import lsd_pkg::*;

	localparam int A_LO = 0;
	localparam int B_LO = SAMPLE_BITS;
	localparam int T_LO = 2 * SAMPLE_BITS;

	logic [HOLD_MS_W-1:0]   hold_ms_q;
	logic [CODE_W-1:0]      stored_code_q;
	logic                   hold_armed_q;
	logic [TIME_BITS-1:0]   change_time_q;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_a_s1;
	logic [SAMPLE_BITS-1:0] sample_b_s1;
	logic [TIME_BITS-1:0]   now_s1;

	logic                   out_valid_q;
	logic [CODE_W-1:0]      out_code_q;
	logic                   out_hold_q;

	logic [CODE_W-1:0]      code_a;
	logic [CODE_W-1:0]      code_b;
	logic [TIME_BITS-1:0]   elapsed;
	logic                   advance;
	logic                   res_valid;
	logic                   res_hold;
	logic [CODE_W-1:0]      res_code;
	logic                   upd_change;
	logic                   upd_disarm;

	lsd_classify #(.SAMPLE_BITS(SAMPLE_BITS)) u_cls_a (
		.sample (sample_a_s1),
		.code   (code_a)
	);

	lsd_classify #(.SAMPLE_BITS(SAMPLE_BITS)) u_cls_b (
		.sample (sample_b_s1),
		.code   (code_b)
	);

	assign cfg_ready = 1'b1;

	// stage 1 retires when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign elapsed = now_s1 - change_time_q;

	always_comb begin
		res_valid  = 1'b0;
		res_hold   = 1'b0;
		res_code   = stored_code_q;
		upd_change = 1'b0;
		upd_disarm = 1'b0;
		if (code_a != stored_code_q) begin
			if (code_a == code_b) begin
				res_valid  = 1'b1;
				res_code   = code_a;
				upd_change = 1'b1;
			end
		end else if (hold_armed_q && (TIME_BITS'(hold_ms_q) < elapsed)) begin
			res_valid  = 1'b1;
			res_hold   = 1'b1;
			upd_disarm = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ms_q <= HOLD_MS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hold_ms_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_code_q <= CODE_NONE;
			hold_armed_q  <= 1'b0;
			change_time_q <= '0;
		end else if (advance) begin
			if (upd_change) begin
				stored_code_q <= code_a;
				hold_armed_q  <= 1'b1;
				change_time_q <= now_s1;
			end else if (upd_disarm) begin
				hold_armed_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_a_s1 <= s_tdata[A_LO +: SAMPLE_BITS];
			sample_b_s1 <= s_tdata[B_LO +: SAMPLE_BITS];
			now_s1      <= s_tdata[T_LO +: TIME_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_code_q <= res_code;
			out_hold_q <= res_hold;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_code_q);
	assign m_tuser  = out_hold_q;

endmodule

`default_nettype wire

// ===== design/lsd_classify.sv =====
// ----------------------------------------------------------------------------
// lsd_classify - ladder sample to switch code
// Counts the thresholds at or below the sample; parallel compares.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_classify #(
	parameter int SAMPLE_BITS = lsd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic [SAMPLE_BITS-1:0]    sample,
	output logic      [lsd_pkg::CODE_W-1:0] code
);
	import lsd_pkg::*;

	logic [THR_W-1:0] sample_ext;

	assign sample_ext = THR_W'(sample);

	always_comb begin
		code = '0;
		for (int i = 0; i < NUM_THR; i++) begin
			if (sample_ext >= THRESH[i]) begin
				code = code + CODE_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_ladder_switch_decoder_with_hold.sv =====
// ----------------------------------------------------------------------------
// tb_ladder_switch_decoder_with_hold - self-checking bench for the ladder decoder
// Polls are driven on the slave stream with random gaps. A local decoder model
// predicts change and hold events. Each event leaving the master stream is
// compared with the oldest prediction. hold_ms is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_ladder_switch_decoder_with_hold;

	import lsd_pkg::*;

	localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
	localparam int TIME_W       = TIME_BITS_DEF;
	localparam int TDATA_W      = ((2*SAMPLE_W+TIME_W+7)/8)*8;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
	localparam int MAX_GAP      = 6;
	localparam int LONG_STALL   = 150;
	localparam int IDLE_LIMIT   = 2000;
	localparam int PIPE_CYCLES  = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [HOLD_MS_W-1:0] HOLD_RESET_MS = 16'd2000;

	typedef enum logic [CODE_W-1:0] {
		SW_MUTE, SW_BANK, SW_MANPGM, SW_1, SW_2, SW_3, SW_4, SW_5, SW_NONE
	} sw_code_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              hold;
	} sw_event_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [HOLD_MS_W-1:0] cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic [0:0]           m_tuser;

	// decoder model state
	logic [CODE_W-1:0]    cur_code    = SW_NONE;
	logic                 hold_armed  = 1'b0;
	logic [TIME_W-1:0]    press_time  = '0;
	logic [HOLD_MS_W-1:0] hold_limit  = HOLD_RESET_MS;
	sw_event_t            pending_events[$];

	logic [TIME_W-1:0]    poll_ms     = '0;
	bit                   no_gaps     = 1'b0;
	int                   rx_wait     = 0;
	int                   rx_long_stall = 0;
	int                   mismatches  = 0;
	int                   idle_cycles = 0;
	sw_event_t            want;

	ladder_switch_decoder_with_hold i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),  // first_sample, second_sample, now_ms, zero pad
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),  // switch_code, zero pad
		.m_tuser   (m_tuser)   // is_hold
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// lowest sample value that decodes to a code
	function automatic int band_low(input int code);
		case (code)
			SW_MUTE:   return 0;
			SW_BANK:   return 129;
			SW_MANPGM: return 200;
			SW_1:      return 261;
			SW_2:      return 313;
			SW_3:      return 358;
			SW_4:      return 398;
			SW_5:      return 433;
			default:   return 731;
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] classify(input logic [SAMPLE_W-1:0] s);
		int n;
		n = 0;
		for (int c = SW_BANK; c <= SW_NONE; c++)
			if (s >= band_low(c))
				n++;
		return CODE_W'(n);
	endfunction

	function automatic logic [SAMPLE_W-1:0] sample_in(input int code);
		int hi;
		hi = (code == SW_NONE) ? SAMPLE_MAX : band_low(code + 1) - 1;
		return SAMPLE_W'($urandom_range(hi, band_low(code)));
	endfunction

	function automatic void decode_poll(input logic [SAMPLE_W-1:0] a,
			input logic [SAMPLE_W-1:0] b, input logic [TIME_W-1:0] now);
		logic [CODE_W-1:0] ca;
		logic [CODE_W-1:0] cb;
		logic [TIME_W-1:0] elapsed;
		sw_event_t         ev;
		ca = classify(a);
		cb = classify(b);
		elapsed = now - press_time;
		if (ca != cur_code) begin
			if (ca == cb) begin
				cur_code   = ca;
				hold_armed = 1'b1;
				press_time = now;
				ev.code = ca;
				ev.hold = 1'b0;
				pending_events.push_back(ev);
			end
		end else if (hold_armed && elapsed > TIME_W'(hold_limit)) begin
			hold_armed = 1'b0;
			ev.code = cur_code;
			ev.hold = 1'b1;
			pending_events.push_back(ev);
		end
	endfunction

	// next poll time: mostly around the hold window, wraps freely
	function automatic logic [TIME_W-1:0] step_time();
		logic [TIME_W-1:0] dt;
		case ($urandom_range(0, 3))
			0:       dt = $urandom_range(0, 3);
			1:       dt = $urandom_range(0, hold_limit);
			2:       dt = TIME_W'(hold_limit) + $urandom_range(0, 4) - 2;
			default: dt = $urandom_range(0, 2*hold_limit + 10);
		endcase
		return poll_ms + dt;
	endfunction

	task automatic send_poll(input logic [SAMPLE_W-1:0] first_s,
			input logic [SAMPLE_W-1:0] second_s, input logic [TIME_W-1:0] now);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = TDATA_W'({now, second_s, first_s});
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		decode_poll(first_s, second_s, now);
	endtask

	task automatic end_burst();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_hold_ms(input logic [HOLD_MS_W-1:0] v);
		end_burst();
		while (pending_events.size() != 0)
			@(posedge clk);
		// polls without an event may still be in the pipe
		repeat (PIPE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_data  = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		hold_limit = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic report_mismatch(input bit have_want, input sw_event_t w,
			input logic [OUT_W-1:0] got_data, input logic got_hold);
		mismatches++;
		if (mismatches <= 10) begin
			if (have_want)
				$display("%0t: mismatch: exp code %0d hold %0b, got tdata 0x%02h hold %0b",
					$time, w.code, w.hold, got_data, got_hold);
			else
				$display("%0t: event with nothing outstanding: tdata 0x%02h hold %0b",
					$time, got_data, got_hold);
		end
	endtask

	// mostly press-then-stay sequences, the rest noise and broken presses
	task automatic run_random_polls(input int count);
		int done;
		int kind;
		int c;
		int d;
		done = 0;
		while (done < count) begin
			if ($urandom_range(0, 7) == 0)
				no_gaps = !no_gaps;
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				c = $urandom_range(SW_MUTE, SW_NONE);
				poll_ms = step_time();
				send_poll(sample_in(c), sample_in(c), poll_ms);
				done++;
				repeat ($urandom_range(1, 6)) begin
					poll_ms = step_time();
					send_poll(sample_in(c), SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), poll_ms);
					done++;
				end
			end else if (kind <= 7) begin
				poll_ms = step_time();
				send_poll(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
					SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), poll_ms);
				done++;
			end else if (kind == 8) begin
				c = $urandom_range(SW_MUTE, SW_NONE);
				d = (c + $urandom_range(1, 8)) % 9;
				poll_ms = step_time();
				send_poll(sample_in(c), sample_in(d), poll_ms);
				done++;
			end else begin
				poll_ms = $urandom;
				send_poll(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
					SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), poll_ms);
				done++;
			end
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_directed();
		send_poll(10'd1023, 10'd1023, 32'd0);    // no switch, disarmed: nothing
		send_poll(10'd0, 10'd0, 32'd10);         // change to mute
		send_poll(10'd128, 10'd200, 32'd20);     // same code, too early
		send_poll(10'd0, 10'd0, 32'd2010);       // exactly hold_ms: not yet
		send_poll(10'd128, 10'd128, 32'd2011);   // hold
		send_poll(10'd0, 10'd0, 32'd5000);       // disarmed: nothing
		for (int c = SW_BANK; c <= SW_5; c++)
			send_poll(SAMPLE_W'(band_low(c)), SAMPLE_W'(band_low(c + 1) - 1),
				TIME_W'(5000 + 100*c));
		send_poll(10'd731, 10'd730, 32'd6000);   // not confirmed
		send_poll(10'd1023, 10'd731, 32'd6100);  // change to no switch
		send_poll(10'd900, 10'd800, 32'd8101);   // hold on no switch
		send_poll(10'd300, 10'd300, 32'hFFFF_FF00);
		send_poll(10'd300, 10'd0, 32'h0000_0600);   // wrapped, still short
		send_poll(10'd312, 10'd1023, 32'h0000_0710); // wrapped past hold_ms
		poll_ms = 32'h0000_0710;
	endtask

	task automatic test_hold_settings();
		logic [HOLD_MS_W-1:0] v;
		for (int i = 0; i < 4; i++) begin
			case (i)
				0:       v = '0;
				1:       v = '1;
				2:       v = 16'd1;
				default: v = HOLD_MS_W'($urandom_range(50, 5000));
			endcase
			write_hold_ms(v);
			run_random_polls(150);
		end
	endtask

	// receiver stops for a long while; alternating presses fill the pipe
	task automatic test_backpressure();
		no_gaps = 1'b1;
		rx_long_stall = LONG_STALL;
		for (int i = 0; i < 40; i++) begin
			poll_ms = poll_ms + 1;
			if (i % 2 == 0)
				send_poll(sample_in(SW_2), sample_in(SW_2), poll_ms);
			else
				send_poll(sample_in(SW_5), sample_in(SW_5), poll_ms);
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_random();
		run_random_polls(1150);
	endtask

	// receiver: one ready decision per falling edge
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				m_tready = 1'b0;
			end else if (rx_long_stall > 0) begin
				m_tready = 1'b0;
				rx_long_stall--;
			end else if (rx_wait > 0) begin
				m_tready = 1'b0;
				rx_wait--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				want = '0;
				report_mismatch(1'b0, want, m_tdata, m_tuser[0]);
			end else begin
				want = pending_events.pop_front();
				if (m_tdata !== OUT_W'(want.code) || m_tuser[0] !== want.hold)
					report_mismatch(1'b1, want, m_tdata, m_tuser[0]);
			end
			rx_wait = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		end
	end

	// watchdog: cycles with no request moving on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_hold_settings();
		test_backpressure();
		test_random();

		end_burst();
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
